/* rtl/pirl_pkg.sv */
package pirl_pkg;

    // Field widths fixed by the beat formats
    localparam int ACTION_WIDTH = 2;
    localparam int POS_WIDTH    = 5;
    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH  = 5;

    // Default sizing of the list
    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Action codes
    localparam logic [ACTION_WIDTH-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

    // Input beat
    typedef struct packed {
        logic [ACTION_WIDTH-1:0] action;
        logic [POS_WIDTH-1:0]    position;
        logic [VALUE_WIDTH-1:0]  value;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  data_out;
        logic [STATUS_WIDTH-1:0] status;
        logic [COUNT_WIDTH-1:0]  count_out;
    } out_beat_t;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic [POS_WIDTH-1:0] pos;
    } cell_ctrl_t;

endpackage

/* rtl/pirl_cell.sv */
module pirl_cell
    import pirl_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] lower_q,
    input  logic [DATA_WIDTH-1:0] upper_q,
    output logic [DATA_WIDTH-1:0] entry_q,
    output logic [DATA_WIDTH-1:0] sel_data
);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  is_above;
    logic                  is_at;

    // Where this slot sits relative to the addressed position
    assign is_above = INDEX > int'(ctrl.pos);
    assign is_at    = INDEX == int'(ctrl.pos);

    // Insert pulls from below, remove pulls from above
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (is_above) begin
                entry_next = lower_q;
            end else if (is_at) begin
                entry_next = word;
            end
        end else if (ctrl.rem) begin
            if (is_above || is_at) begin
                entry_next = upper_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_q  = entry_reg;
    assign sel_data = is_at ? entry_reg : '0;

endmodule

/* rtl/positional_insert_remove_list.sv */
// Positional insert/remove list built as a chain of shifting cells.
// A result appears in the output register in the cycle after its beat is taken.
// Throughput: one beat per cycle while m_ready is high; the cells shift in parallel.
// Reset (aresetn low, synchronous) empties the list and drops any pending result;
// the cell contents are not cleared and are only read after being written.
module positional_insert_remove_list
    import pirl_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_payload
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_WIDTH) ? CNT_W : POS_WIDTH;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    out_beat_t             out_reg;
    out_beat_t             out_next;

    logic                  accept;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;
    logic                  in_range;
    logic                  ins_ok;
    logic                  rem_ok;
    logic                  rd_ok;
    logic [DATA_WIDTH-1:0] word;
    logic [DATA_WIDTH-1:0] read_data;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_q   [DEPTH];
    logic [DATA_WIDTH-1:0] cell_sel [DEPTH];

    // Handshake: take a beat whenever the output register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Decode
    assign pos_c    = CMP_W'(s_payload.position);
    assign cnt_c    = CMP_W'(count_reg);
    assign in_range = pos_c < cnt_c;
    assign ins_ok   = (s_payload.action == ACT_INSERT) && !(pos_c > cnt_c)
                      && (cnt_c < CMP_W'(DEPTH));
    assign rem_ok   = (s_payload.action == ACT_REMOVE) && in_range;
    assign rd_ok    = (s_payload.action == ACT_READ) && in_range;
    assign word     = DATA_WIDTH'(s_payload.value);

    assign ctrl.ins = accept && ins_ok;
    assign ctrl.rem = accept && rem_ok;
    assign ctrl.pos = s_payload.position;

    // Cell chain
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        if (k == 0) begin : g_lo_end
            assign lower = word;
        end else begin : g_lo
            assign lower = cell_q[k-1];
        end

        if (k == DEPTH - 1) begin : g_hi_end
            assign upper = cell_q[k];
        end else begin : g_hi
            assign upper = cell_q[k+1];
        end

        pirl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (k)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .word     (word),
            .lower_q  (lower),
            .upper_q  (upper),
            .entry_q  (cell_q[k]),
            .sel_data (cell_sel[k])
        );
    end

    // Only the addressed cell drives nonzero select data
    always_comb begin
        read_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            read_data = read_data | cell_sel[k];
        end
    end

    // Count and result
    always_comb begin
        count_next         = count_reg;
        out_next.data_out  = '0;
        out_next.status    = ST_RANGE;
        case (s_payload.action)
            ACT_INSERT: begin
                if (pos_c > cnt_c) begin
                    out_next.status = ST_RANGE;
                end else if (!ins_ok) begin
                    out_next.status = ST_FULL;
                end else begin
                    out_next.status = ST_OK;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (rem_ok) begin
                    out_next.status   = ST_OK;
                    out_next.data_out = VALUE_WIDTH'(read_data);
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            ACT_READ: begin
                if (rd_ok) begin
                    out_next.status   = ST_OK;
                    out_next.data_out = VALUE_WIDTH'(read_data);
                end
            end
            default: begin
                out_next.status = ST_RANGE;
            end
        endcase
        out_next.count_out = COUNT_WIDTH'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

/* tb/tb_positional_insert_remove_list.sv */
`timescale 1ns / 1ps

module tb_positional_insert_remove_list;
    import pirl_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEFAULT;
    localparam int RANDOM_BEATS = 1100;
    localparam int HOLD_CYCLES  = 80;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_LIMIT  = 1000;
    localparam int IN_BITS      = $bits(in_beat_t);

    // Action code the block does not define
    localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

    // One row of the directed stimulus
    typedef struct {
        in_beat_t  beat;
        int        reps;
        bit        typed;
        out_beat_t result;
    } dir_row_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_beat_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_beat_t m_payload;

    // Hand-typed expectation that travels with the beat on offer
    bit        offer_typed = 1'b0;
    out_beat_t offer_exp   = '0;

    // Shadow copy of the list
    logic [VALUE_WIDTH-1:0] list_words [LIST_DEPTH];
    int list_count = 0;

    out_beat_t pending_results [$];
    dir_row_t  dir_rows [$];

    int err_count      = 0;
    int beats_in       = 0;
    int results_seen   = 0;
    int full_refusals  = 0;
    int range_refusals = 0;
    int fill_target    = 0;
    bit hold_req       = 1'b0;
    bit tx_quiet       = 1'b0;
    bit rx_quiet       = 1'b0;

    positional_insert_remove_list dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #1 aclk = ~aclk;

    // Apply one operation to the shadow list and return the result it gives
    function automatic out_beat_t apply_list_op(in_beat_t b);
        out_beat_t r;
        int p;
        int k;
        r = '0;
        p = int'(b.position);
        case (b.action)
            ACT_INSERT: begin
                if (p > list_count) begin
                    r.status = ST_RANGE;
                end else if (list_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = list_count; k > p; k--)
                        list_words[k] = list_words[k-1];
                    list_words[p] = b.value;
                    list_count++;
                end
            end
            ACT_REMOVE: begin
                if (p >= list_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data_out = list_words[p];
                    for (k = p; k + 1 < list_count; k++)
                        list_words[k] = list_words[k+1];
                    list_count--;
                end
            end
            ACT_READ: begin
                if (p >= list_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data_out = list_words[p];
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        r.count_out = COUNT_WIDTH'(list_count);
        return r;
    endfunction

    // Random operation: mostly in-range work steering the fill level toward a target
    function automatic in_beat_t gen_list_op();
        in_beat_t b;
        int c;
        int roll;
        c    = list_count;
        roll = $urandom_range(0, 99);
        b.value = $urandom;
        if ($urandom_range(0, 9) == 0)
            b.value = $urandom_range(0, 1) ? '1 : '0;
        if (roll < 3) begin
            b.action   = ACT_UNUSED;
            b.position = POS_WIDTH'($urandom_range(0, 31));
        end else if (roll < 8) begin
            b.action   = ACTION_WIDTH'($urandom_range(0, 2));
            b.position = POS_WIDTH'($urandom_range(c, 31));
        end else if (roll < 28 && c > 0) begin
            b.action   = ACT_READ;
            b.position = POS_WIDTH'($urandom_range(0, c - 1));
        end else if (c == 0 || c < fill_target ||
                     (c == fill_target && $urandom_range(0, 1) == 0)) begin
            b.action   = ACT_INSERT;
            b.position = POS_WIDTH'($urandom_range(0, c));
        end else begin
            b.action   = ACT_REMOVE;
            b.position = POS_WIDTH'($urandom_range(0, c - 1));
        end
        return b;
    endfunction

    task automatic add_row(logic [ACTION_WIDTH-1:0] act, int pos, logic [VALUE_WIDTH-1:0] val,
                           int reps, bit typed, logic [VALUE_WIDTH-1:0] d,
                           logic [STATUS_WIDTH-1:0] st, int cnt);
        dir_row_t row;
        row.beat.action      = act;
        row.beat.position    = POS_WIDTH'(pos);
        row.beat.value       = val;
        row.reps             = reps;
        row.typed            = typed;
        row.result.data_out  = d;
        row.result.status    = st;
        row.result.count_out = COUNT_WIDTH'(cnt);
        dir_rows.push_back(row);
    endtask

    // Offer one beat and hold it until the block takes it
    task automatic send_beat(in_beat_t b, bit typed, out_beat_t exp_r);
        s_payload   <= b;
        s_valid     <= 1'b1;
        offer_typed <= typed;
        offer_exp   <= exp_r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random sender idle burst, junk on the payload while valid is low
    task automatic sender_gap();
        if (!tx_quiet && $urandom_range(0, 4) == 0) begin
            s_valid   <= 1'b0;
            s_payload <= IN_BITS'({$urandom, $urandom});
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Wait until every expected result has come back
    task automatic drain_results(int limit);
        int n;
        n = 0;
        @(posedge aclk);
        while (pending_results.size() != 0 && n < limit) begin
            @(posedge aclk);
            n++;
        end
    endtask

    // Prediction on accepted beats, checking on accepted results
    always @(posedge aclk) begin : result_check
        out_beat_t exp_r;
        out_beat_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                exp_r = apply_list_op(s_payload);
                if (exp_r.status == ST_FULL)
                    full_refusals++;
                else if (exp_r.status == ST_RANGE)
                    range_refusals++;
                pending_results.push_back(offer_typed ? offer_exp : exp_r);
                beats_in++;
            end
            if (m_valid && m_ready) begin
                got = m_payload;
                results_seen++;
                if (pending_results.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_SHOWN)
                        $display("unexpected result beat: data=%h status=%0d count=%0d",
                                 got.data_out, got.status, got.count_out);
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.data_out !== exp_r.data_out || got.status !== exp_r.status ||
                        got.count_out !== exp_r.count_out) begin
                        err_count++;
                        if (err_count <= MAX_SHOWN)
                            $display("mismatch #%0d exp %h/%0d/%0d got %h/%0d/%0d",
                                     results_seen, exp_r.data_out, exp_r.status,
                                     exp_r.count_out, got.data_out, got.status,
                                     got.count_out);
                    end
                end
            end
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (rx_quiet || $urandom_range(0, 5) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 5)) @(posedge aclk);
            end
        end
    end

    // Watchdog
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        in_beat_t b;
        int i;
        int r;

        // Empty list: everything but a front insert is refused
        add_row(ACT_READ,   0,  32'h0000_0000, 1, 1, 32'h0, ST_RANGE, 0);
        add_row(ACT_REMOVE, 0,  32'hFFFF_FFFF, 1, 1, 32'h0, ST_RANGE, 0);
        add_row(ACT_INSERT, 1,  32'h1234_5678, 1, 1, 32'h0, ST_RANGE, 0);
        add_row(ACT_UNUSED, 0,  32'h0000_0000, 1, 1, 32'h0, ST_RANGE, 0);
        // Front, front, back inserts
        add_row(ACT_INSERT, 0,  32'hFFFF_FFFF, 1, 1, 32'h0, ST_OK, 1);
        add_row(ACT_INSERT, 0,  32'h0000_0000, 1, 1, 32'h0, ST_OK, 2);
        add_row(ACT_INSERT, 2,  32'hA5A5_A5A5, 1, 1, 32'h0, ST_OK, 3);
        add_row(ACT_READ,   1,  32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_OK, 3);
        add_row(ACT_READ,   3,  32'h0000_0000, 1, 1, 32'h0, ST_RANGE, 3);
        add_row(ACT_REMOVE, 0,  32'h0000_0000, 1, 1, 32'h0, ST_OK, 2);
        // Top position code
        add_row(ACT_READ,   31, 32'hFFFF_FFFF, 1, 1, 32'h0, ST_RANGE, 2);
        add_row(ACT_INSERT, 31, 32'h5A5A_5A5A, 1, 1, 32'h0, ST_RANGE, 2);
        // Fill to the brim, then full and range refusals
        add_row(ACT_INSERT, 1,  32'h3C3C_0000, 14, 0, 32'h0, ST_OK, 0);
        add_row(ACT_INSERT, 16, 32'h0000_0000, 1, 1, 32'h0, ST_FULL, 16);
        add_row(ACT_INSERT, 17, 32'h0000_0000, 1, 1, 32'h0, ST_RANGE, 16);
        add_row(ACT_READ,   15, 32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(ACT_READ,   16, 32'h0000_0000, 1, 1, 32'h0, ST_RANGE, 16);
        add_row(ACT_REMOVE, 15, 32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(ACT_REMOVE, 0,  32'h0000_0000, 1, 0, 32'h0, ST_OK, 0);
        add_row(ACT_UNUSED, 31, 32'hFFFF_FFFF, 1, 1, 32'h0, ST_RANGE, 14);
        add_row(ACT_REMOVE, 14, 32'h0000_0000, 1, 1, 32'h0, ST_RANGE, 14);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows
        for (i = 0; i < dir_rows.size(); i++) begin
            for (r = 0; r < dir_rows[i].reps; r++) begin
                b = dir_rows[i].beat;
                b.value = b.value + VALUE_WIDTH'(r);
                send_beat(b, dir_rows[i].typed, dir_rows[i].result);
                sender_gap();
            end
        end

        // Random traffic
        for (i = 0; i < RANDOM_BEATS; i++) begin
            if (i % 40 == 0) begin
                if ($urandom_range(0, 3) == 0)
                    fill_target = LIST_DEPTH;
                else if ($urandom_range(0, 3) == 0)
                    fill_target = 0;
                else
                    fill_target = $urandom_range(0, LIST_DEPTH);
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            // Long result-side hold-off while beats keep coming
            if (i == 300)
                hold_req = 1'b1;
            if (i >= 300 && i < 340)
                tx_quiet = 1'b1;
            // Sender pause until the block has answered everything
            if (i == 600) begin
                s_valid <= 1'b0;
                drain_results(DRAIN_LIMIT);
            end
            if (i >= RANDOM_BEATS - 150) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            send_beat(gen_list_op(), 1'b0, '0);
            sender_gap();
        end
        s_valid <= 1'b0;

        drain_results(DRAIN_LIMIT);
        repeat (5) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            err_count += pending_results.size();
        end

        $display("Covered %0d operations, %0d results checked.", beats_in, results_seen);
        $display("Refusals seen: %0d full-list, %0d bad position/action.",
                 full_refusals, range_refusals);
        $display("Mismatches counted: %0d", err_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
